// ===== rtl/core/hdlcd_pkg.sv =====
package hdlcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CRC_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 2'd1;

    localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'h7D;
    localparam logic [BYTE_W-1:0] STUFF_MASK      = 8'h20;

    // CRC-16/X25, reflected form
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT    = 16'hFFFF;

endpackage

// ===== rtl/core/hdlcd_if.sv =====
// Raw line byte stream
interface hdlcd_byte_if import hdlcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result stream
interface hdlcd_res_if import hdlcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] item_kind;

    modport source (output valid, output out_byte, output item_kind, input ready);
    modport sink   (input valid, input out_byte, input item_kind, output ready);
endinterface

// Register write channel
interface hdlcd_cfg_if import hdlcd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hdlcd_crc16.sv =====
module hdlcd_crc16
    import hdlcd_pkg::*;
(
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [BYTE_W-1:0] i_data,
    output logic [CRC_W-1:0]  o_crc
);

    // Fold one byte in, LSB first
    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_data};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// ===== rtl/core/hdlc_deframer_crc16_check.sv =====
// Channel  Port   Dir  Payload               Transaction
// -------  -----  ---  --------------------  ------------------
// input    i_in   in   rx_byte[7:0]          valid && ready
// result   o_out  out  out_byte, item_kind   valid && ready
// config   i_cfg  in   index[1:0], data      valid && ready
//
// One byte per cycle sustained while results are taken; a result passes the input
// register, then the state/CRC pass into the result register.
// The byte-wide CRC update sits between those two registers.
// Reset (synchronous, active low) returns to hunting with default registers.
// A stalled result holds the pass stage; the input register still takes one
// more byte, so input ready drops only when both stages are full.
module hdlc_deframer_crc16_check
    import hdlcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    hdlcd_byte_if.sink    i_in,
    hdlcd_res_if.source   o_out,
    hdlcd_cfg_if.sink     i_cfg
);

    // Configuration registers
    logic [BYTE_W-1:0] r_delim;
    logic [BYTE_W-1:0] r_esc;

    // Input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Frame state
    logic              r_in_frame, n_in_frame;
    logic              r_esc_pend, n_esc_pend;
    logic [BYTE_W-1:0] r_held0, n_held0;
    logic [BYTE_W-1:0] r_held1, n_held1;
    logic [1:0]        r_held_cnt, n_held_cnt;
    logic [CRC_W-1:0]  r_crc, n_crc;

    // Result stage
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [KIND_W-1:0] r_out_kind;

    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic [KIND_W-1:0] res_kind;
    logic [CRC_W-1:0]  crc_upd;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.item_kind = r_out_kind;

    hdlcd_crc16 u_crc (
        .i_crc  (r_crc),
        .i_data (r_held0),
        .o_crc  (crc_upd)
    );

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIMITER_RESET;
            r_esc   <= ESCAPE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_DELIMITER: r_delim <= i_cfg.data;
                REG_ESCAPE:    r_esc   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Capture input byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    // Deframe one byte: hunt, unstuff, hold two bytes, check CRC at close
    always_comb begin
        logic              push_en;
        logic [BYTE_W-1:0] push_data;
        logic              restart;

        n_in_frame = r_in_frame;
        n_esc_pend = r_esc_pend;
        n_held0    = r_held0;
        n_held1    = r_held1;
        n_held_cnt = r_held_cnt;
        n_crc      = r_crc;
        res_valid  = 1'b0;
        res_byte   = '0;
        res_kind   = KIND_DATA;
        push_en    = 1'b0;
        push_data  = r_in_byte;
        restart    = 1'b0;

        if (!r_in_frame) begin
            if (r_in_byte == r_delim) begin
                n_in_frame = 1'b1;
                restart    = 1'b1;
            end
        end else if (r_esc_pend) begin
            n_esc_pend = 1'b0;
            push_en    = 1'b1;
            push_data  = r_in_byte ^ STUFF_MASK;
        end else if (r_in_byte == r_delim) begin
            // short frame restarts; otherwise close with a CRC verdict
            if (r_held_cnt == 2'd2) begin
                res_valid  = 1'b1;
                res_kind   = ({r_held1, r_held0} == (r_crc ^ CRC_XOROUT)) ?
                             KIND_GOOD : KIND_BAD;
                n_in_frame = 1'b0;
            end
            restart = 1'b1;
        end else if (r_in_byte == r_esc) begin
            n_esc_pend = 1'b1;
        end else begin
            push_en = 1'b1;
        end

        // Shift data through the two-byte holding line
        if (push_en) begin
            if (r_held_cnt != 2'd2) begin
                if (!r_held_cnt[0]) begin
                    n_held0 = push_data;
                end else begin
                    n_held1 = push_data;
                end
                n_held_cnt = r_held_cnt + 2'd1;
            end else begin
                res_valid = 1'b1;
                res_byte  = r_held0;
                res_kind  = KIND_DATA;
                n_crc     = crc_upd;
                n_held0   = r_held1;
                n_held1   = push_data;
            end
        end

        if (restart) begin
            n_esc_pend = 1'b0;
            n_held0    = '0;
            n_held1    = '0;
            n_held_cnt = 2'd0;
            n_crc      = CRC_INIT;
        end
    end

    // Commit frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc_pend <= 1'b0;
            r_held0    <= '0;
            r_held1    <= '0;
            r_held_cnt <= 2'd0;
            r_crc      <= CRC_INIT;
        end else if (advance) begin
            r_in_frame <= n_in_frame;
            r_esc_pend <= n_esc_pend;
            r_held0    <= n_held0;
            r_held1    <= n_held1;
            r_held_cnt <= n_held_cnt;
            r_crc      <= n_crc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_byte <= res_byte;
            r_out_kind <= res_kind;
        end
    end

`ifndef SYNTHESIS
    // a frame closed with a CRC verdict sends the block back to hunting
    a_close_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid && res_kind != KIND_DATA) |=> !r_in_frame)
        else $error("frame end did not return to hunting");

    // an escape is only pending inside a frame
    a_esc_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_pend |-> r_in_frame)
        else $error("escape pending while hunting");

    // holding line never overfills
    a_held_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd3)
        else $error("holding count out of range");

    // a payload byte only leaves once the line is full
    a_data_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid && res_kind == KIND_DATA) |-> (r_held_cnt == 2'd2))
        else $error("payload byte released early");
`endif

endmodule

// ===== tb/tb_hdlc_deframer_crc16_check.sv =====
`timescale 1ns / 1ps

module tb_hdlc_deframer_crc16_check;
    import hdlcd_pkg::*;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    typedef struct {
        logic [BYTE_W-1:0] payload;
        logic [KIND_W-1:0] kind;
    } t_deframed;

    logic i_clk;
    logic i_rst_n;

    hdlcd_byte_if in_if();
    hdlcd_res_if  out_if();
    hdlcd_cfg_if  cfg_if();

    hdlc_deframer_crc16_check u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predicted deframer state and register copies
    logic              st_in_frame;
    logic              st_esc_pending;
    logic [BYTE_W-1:0] st_held[2];
    logic [1:0]        st_held_cnt;
    logic [CRC_W-1:0]  st_crc;
    logic [BYTE_W-1:0] reg_delim;
    logic [BYTE_W-1:0] reg_esc;

    // Deframed items still owed by the block, oldest first
    t_deframed deframed_q[$];

    // Register values the stimulus builds frames with
    logic [BYTE_W-1:0] cur_delim;
    logic [BYTE_W-1:0] cur_esc;

    int   mismatch_count;
    int   sent_count;
    int   burst_left;
    bit   tx_steady;
    int   rx_mode;
    logic [12:0] stall_pat;

    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One byte-wide step of the reflected CRC-16/X25
    function automatic logic [CRC_W-1:0] crc_x25_next(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    function automatic void restart_frame();
        st_esc_pending = 1'b0;
        st_held[0]     = '0;
        st_held[1]     = '0;
        st_held_cnt    = '0;
        st_crc         = CRC_INIT;
    endfunction

    // Push a data byte through the two-byte hold line; release the oldest once full
    function automatic void hold_byte(input logic [BYTE_W-1:0] b);
        t_deframed r;
        if (st_held_cnt < 2) begin
            st_held[st_held_cnt[0]] = b;
            st_held_cnt = st_held_cnt + 2'd1;
        end else begin
            r.payload = st_held[0];
            r.kind    = KIND_DATA;
            deframed_q = {deframed_q, r};
            st_crc     = crc_x25_next(st_crc, st_held[0]);
            st_held[0] = st_held[1];
            st_held[1] = b;
        end
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] c);
        t_deframed        r;
        logic [CRC_W-1:0] fcs_rx;
        if (!st_in_frame) begin
            if (c == reg_delim) begin
                st_in_frame = 1'b1;
                restart_frame();
            end
        end else if (st_esc_pending) begin
            st_esc_pending = 1'b0;
            hold_byte(c ^ STUFF_MASK);
        end else if (c == reg_delim) begin
            // Too few bytes for a CRC: drop them and restart the frame
            if (st_held_cnt < 2) begin
                restart_frame();
            end else begin
                fcs_rx    = {st_held[1], st_held[0]};
                r.payload = '0;
                r.kind    = (fcs_rx == (st_crc ^ CRC_XOROUT)) ? KIND_GOOD : KIND_BAD;
                deframed_q = {deframed_q, r};
                st_in_frame = 1'b0;
                restart_frame();
            end
        end else if (c == reg_esc) begin
            st_esc_pending = 1'b1;
        end else begin
            hold_byte(c);
        end
    endfunction

    // Track register writes, predict on input transactions, check result transactions
    always @(posedge i_clk) begin
        t_deframed exp_r;
        if (!i_rst_n) begin
            reg_delim   = DELIMITER_RESET;
            reg_esc     = ESCAPE_RESET;
            st_in_frame = 1'b0;
            restart_frame();
            deframed_q.delete();
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == REG_DELIMITER)
                    reg_delim = cfg_if.data;
                else if (cfg_if.index == REG_ESCAPE)
                    reg_esc = cfg_if.data;
            end
            if (in_if.valid && in_if.ready)
                deframe_byte(in_if.rx_byte);
            if (out_if.valid && out_if.ready) begin
                if (deframed_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: got byte %02h kind %0d", $time,
                             out_if.out_byte, out_if.item_kind);
                end else begin
                    exp_r = deframed_q.pop_front();
                    if (out_if.out_byte !== exp_r.payload ||
                        out_if.item_kind !== exp_r.kind) begin
                        mismatch_count++;
                        $display({"%0t: result mismatch: expected byte %02h kind %0d, ",
                                  "got byte %02h kind %0d"},
                                 $time, exp_r.payload, exp_r.kind,
                                 out_if.out_byte, out_if.item_kind);
                    end
                end
            end
        end
    end

    // Stall the result side on a rotating pattern, plain or thinned at random per mode, or never in mode 1
    always @(negedge i_clk) begin
        stall_pat <= {stall_pat[11:0], stall_pat[12]};
        case (rx_mode)
            1: begin
                out_if.ready <= 1'b1;
            end
            2: begin
                out_if.ready <= stall_pat[12] & ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_if.ready <= stall_pat[12];
            end
        endcase
    end

    // Send one raw byte; open a random gap whenever a burst runs out
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_bytes(input t_byte_q q);
        foreach (q[k]) send_byte(q[k]);
    endtask

    // Frame a payload: open, stuffed body with FCS low byte first, close
    task automatic send_frame(input t_byte_q payload, input bit corrupt, input int stuff_pct);
        logic [CRC_W-1:0] fcs;
        t_byte_q          body;
        fcs = CRC_INIT;
        foreach (payload[k]) fcs = crc_x25_next(fcs, payload[k]);
        fcs = fcs ^ CRC_XOROUT;
        if (corrupt)
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        body = {payload, fcs[7:0], fcs[15:8]};
        send_byte(cur_delim);
        // A doubled opening delimiter lands as a short frame
        if ($urandom_range(0, 9) == 0)
            send_byte(cur_delim);
        foreach (body[k]) begin
            if (body[k] == cur_delim || body[k] == cur_esc ||
                $urandom_range(0, 99) < stuff_pct) begin
                send_byte(cur_esc);
                send_byte(body[k] ^ STUFF_MASK);
            end else begin
                send_byte(body[k]);
            end
        end
        send_byte(cur_delim);
    endtask

    // Random byte, leaning toward the delimiter, the escape and the escaped delimiter
    function automatic logic [BYTE_W-1:0] pick_byte(input int odds);
        int r;
        r = $urandom_range(0, odds);
        if (r == 0)
            return cur_delim;
        if (r == 1)
            return cur_esc;
        if (r == 2)
            return cur_delim ^ STUFF_MASK;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Drop input valid, drain owed results, then let the pipeline settle
    task automatic go_idle();
        in_if.valid <= 1'b0;
        while (deframed_q.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] esc,
                             input bit with_unused);
        go_idle();
        // Writes to unused indexes must leave both registers alone
        if (with_unused) begin
            write_reg(CFG_IDX_W'(2), BYTE_W'($urandom_range(0, 255)));
            write_reg(CFG_IDX_W'(3), BYTE_W'($urandom_range(0, 255)));
        end
        write_reg(REG_DELIMITER, delim);
        write_reg(REG_ESCAPE, esc);
        cfg_if.valid <= 1'b0;
        cur_delim = delim;
        cur_esc   = esc;
    endtask

    // Mostly well-formed frames, the rest line noise, broken and short frames
    task automatic run_traffic(input int n_items);
        int      stop_at;
        int      r;
        int      n;
        t_byte_q q;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            r = $urandom_range(0, 99);
            q.delete();
            if (r < 70) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
                repeat (n) q = {q, pick_byte(24)};
                send_frame(q, $urandom_range(0, 6) == 0, ($urandom_range(0, 3) == 0) ? 15 : 0);
            end else if (r < 82) begin
                repeat ($urandom_range(1, 6)) send_byte(pick_byte(6));
            end else if (r < 92) begin
                send_byte(cur_delim);
                repeat ($urandom_range(0, 8)) send_byte(pick_byte(6));
                send_byte(cur_delim);
            end else begin
                send_byte(cur_delim);
                if ($urandom_range(0, 1))
                    send_byte(pick_byte(3));
                send_byte(cur_delim);
            end
        end
    endtask

    // Noise while hunting, short frames restarting, a frame that is only an FCS
    task automatic test_hunt_and_short_frames();
        send_bytes('{8'hFF, 8'h00, 8'h7E, 8'h41, 8'h7E, 8'h00, 8'h00, 8'h7E});
    endtask

    // Every byte escaped, including an escaped delimiter and escape; then a bad FCS
    task automatic test_stuffing_and_crc();
        send_frame('{8'h7E, 8'h7D, 8'h5E, 8'h00, 8'hFF}, 1'b0, 100);
        send_frame('{8'h01}, 1'b1, 0);
    endtask

    // Register extremes, unused indexes, and delimiter equal to escape
    task automatic test_register_extremes();
        configure(8'h00, 8'hFF, 1'b1);
        run_traffic(60);
        configure(8'hFF, 8'h00, 1'b1);
        run_traffic(60);
        // Same value for both: the delimiter meaning must win
        configure(8'h55, 8'h55, 1'b0);
        send_bytes('{8'h55, 8'h11, 8'h22, 8'h33, 8'h55, 8'h55, 8'h55, 8'h00, 8'h00, 8'h55});
        run_traffic(40);
    endtask

    // Several register settings with different sender and receiver pacing
    task automatic test_random_traffic();
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] e;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                configure(DELIMITER_RESET, ESCAPE_RESET, 1'b0);
            end else begin
                d = BYTE_W'($urandom_range(0, 255));
                e = BYTE_W'($urandom_range(0, 255));
                while (e == d) e = BYTE_W'($urandom_range(0, 255));
                configure(d, e, ph == 3);
            end
            tx_steady = (ph % 3 == 1);
            rx_mode   = ph % 3;
            run_traffic(150);
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.rx_byte  = '0;
        out_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        stall_pat      = 13'b1101100111010;
        rx_mode        = 0;
        tx_steady      = 1'b0;
        burst_left     = 0;
        sent_count     = 0;
        mismatch_count = 0;
        cur_delim      = DELIMITER_RESET;
        cur_esc        = ESCAPE_RESET;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_hunt_and_short_frames();
        test_stuffing_and_crc();
        test_register_extremes();
        test_random_traffic();
        go_idle();

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
